// ----- rtl/mrbl_pkg.sv -----
`default_nettype none
package mrbl_pkg;

	localparam int MAX_SIDE_DEF   = 256;
	localparam int MAX_POINTS_DEF = 16384;

	// action codes
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD   = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	// configuration register indexes
	localparam logic REG_CITY_WIDTH  = 1'b0;
	localparam logic REG_CITY_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0] action;
		logic [8:0] point_x;
		logic [8:0] point_y;
		logic [8:0] radius;
	} item_t;

	typedef struct packed {
		logic [14:0] best_count;
		logic [8:0]  best_x;
		logic [8:0]  best_y;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/manhattan_radius_best_location_unit.sv -----
`default_nettype none
// Manhattan radius best location unit.
// Command channel: item is taken when start is high and busy is low.
// A clear or add transfer completes in that cycle and gives no result;
// an add is dropped when the point lies outside the city or the store is full.
// A query transfer keeps busy high until its result is shown: result is valid
// for exactly one cycle with done high. The receiver cannot stall it.
// For each stored point a query makes one point store read and up to four
// read-modify-write updates of the count grid memory, then it scans the
// (W+H+1) x (W+H+1) rotated grid with one grid read per cycle.
// The count grid is zeroed behind the scan, so no clear pass per query.
// After reset the block sweeps the whole count grid once, one cell a cycle,
// with busy high. Configuration writes (cfg_we, cfg_idx, cfg_data) take
// effect at once; the user must make them only while the block is idle, as
// the block does not enforce this. Values saturate to [1, MAX_SIDE].
// Reset empties the point set and sets width and height to min(MAX_SIDE, 256).
module manhattan_radius_best_location_unit #(
	parameter int MAX_SIDE   = mrbl_pkg::MAX_SIDE_DEF,
	parameter int MAX_POINTS = mrbl_pkg::MAX_POINTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire mrbl_pkg::item_t   item,
	output logic                   done,
	output mrbl_pkg::result_t      result,
	input  wire logic              cfg_we,
	input  wire logic              cfg_idx,
	input  wire logic [8:0]        cfg_data
);
	import mrbl_pkg::*;

	localparam int GRID_SIDE = 2 * MAX_SIDE + 2;
	localparam int CW        = $clog2(GRID_SIDE);
	localparam int CWR       = (CW > 10) ? CW : 10;
	localparam int SW        = CWR + 2;
	localparam int SIDEW     = $clog2(MAX_SIDE + 1);
	localparam int PCW       = $clog2(MAX_POINTS + 1);
	localparam int PAW       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int VW        = PCW + 1;
	localparam int GDEPTH    = GRID_SIDE * (2 ** CW);
	localparam int SIDE_RST  = (MAX_SIDE < 256) ? MAX_SIDE : 256;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_PT_RD, ST_PT_LAT, ST_C_RD, ST_C_WR,
		ST_SCAN, ST_SCAN_END, ST_DONE
	} state_t;

	state_t state_q;

	logic [SIDEW-1:0] width_q, height_q;
	logic [PCW-1:0]   count_q, p_q;
	logic [8:0]       radius_q;
	logic [CW-1:0]    si_q, sj_q;
	logic [1:0]       k_q;
	logic [CW-1:0]    crow_q [4];
	logic [CW-1:0]    ccol_q [4];
	logic [3:0]       cok_q;
	logic             valid_s1;
	logic [CW-1:0]    i_s1, j_s1;
	logic [VW-1:0]    rowacc_q, best_q;
	logic [CW-1:0]    bx_q, by_q;

	// point store
	logic              pt_we;
	logic [2*CW-1:0]   pt_wdata, pt_rdata;

	// count grid and previous-row line buffer
	logic              gr_we;
	logic [2*CW-1:0]   gr_waddr, gr_raddr;
	logic [VW-1:0]     gr_wdata, gr_rdata;
	logic [VW-1:0]     lb_rdata, val;

	logic [SIDEW-1:0]  sat_data;
	logic              accept, in_city;
	logic [CW-1:0]     g;

	mrbl_ram #(.W(2 * CW), .DEPTH(MAX_POINTS), .AW(PAW)) u_points (
		.clk   (clk),
		.we    (pt_we),
		.waddr (count_q[PAW-1:0]),
		.wdata (pt_wdata),
		.raddr (p_q[PAW-1:0]),
		.rdata (pt_rdata)
	);

	mrbl_ram #(.W(VW), .DEPTH(GDEPTH), .AW(2 * CW)) u_grid (
		.clk   (clk),
		.we    (gr_we),
		.waddr (gr_waddr),
		.wdata (gr_wdata),
		.raddr (gr_raddr),
		.rdata (gr_rdata)
	);

	mrbl_ram #(.W(VW), .DEPTH(GRID_SIDE), .AW(CW)) u_line (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (j_s1),
		.wdata (val),
		.raddr (sj_q),
		.rdata (lb_rdata)
	);

	// saturate configuration value to [1, MAX_SIDE]
	always_comb begin
		if (cfg_data == 9'd0) begin
			sat_data = SIDEW'(1);
		end else if (32'(cfg_data) > MAX_SIDE) begin
			sat_data = SIDEW'(MAX_SIDE);
		end else begin
			sat_data = SIDEW'(cfg_data);
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign g      = CW'(width_q) + CW'(height_q) + CW'(1);

	// add command: store rotated coordinates
	always_comb begin
		in_city = (item.point_x != 9'd0) && (32'(item.point_x) <= 32'(width_q)) &&
		          (item.point_y != 9'd0) && (32'(item.point_y) <= 32'(height_q));
		pt_we   = accept && (item.action == ACT_ADD) && in_city &&
		          (32'(count_q) < MAX_POINTS);
		pt_wdata = {CW'(item.point_x) + CW'(item.point_y),
		            CW'(item.point_x) + CW'(MAX_SIDE) - CW'(item.point_y)};
	end

	// corner placement from the fetched point
	logic signed [SW-1:0] u_s, v_s, r_s, g_s;
	logic signed [SW-1:0] a_lo, a_hi, b_lo, b_hi;
	logic signed [SW-1:0] cr [4];
	logic signed [SW-1:0] cc [4];

	always_comb begin
		u_s  = SW'(pt_rdata[2*CW-1:CW]);
		v_s  = SW'(pt_rdata[CW-1:0]) - SW'(MAX_SIDE) + SW'(height_q);
		r_s  = SW'(radius_q);
		g_s  = SW'(g);
		a_lo = u_s - r_s;
		a_hi = u_s + r_s + SW'(1);
		b_lo = v_s - r_s;
		b_hi = v_s + r_s + SW'(1);
		cr[0] = a_lo; cc[0] = b_lo;
		cr[1] = a_hi; cc[1] = b_hi;
		cr[2] = a_lo; cc[2] = b_hi;
		cr[3] = a_hi; cc[3] = b_lo;
	end

	// scan datapath: prefix sum and candidate compare
	logic [VW-1:0]        rs;
	logic signed [SW-1:0] s_s, x_s, y_s, ys_s;
	logic                 qual, win;

	always_comb begin
		rs   = ((j_s1 == '0) ? '0 : rowacc_q) + gr_rdata;
		val  = ((i_s1 == '0) ? '0 : lb_rdata) + rs;
		s_s  = SW'(i_s1) + SW'(j_s1) - SW'(height_q);
		ys_s = SW'(i_s1) - SW'(j_s1) + SW'(height_q);
		x_s  = s_s >>> 1;
		y_s  = ys_s >>> 1;
		qual = (s_s > 0) && !s_s[0] && (x_s >= 1) && (x_s <= SW'(width_q)) &&
		       (y_s >= 1) && (y_s <= SW'(height_q));
		if (val == best_q) begin
			win = (CW'(y_s) == by_q) ? (CW'(x_s) < bx_q) : (CW'(y_s) < by_q);
		end else begin
			win = val > best_q;
		end
	end

	// grid memory port selection
	always_comb begin
		gr_raddr = {si_q, sj_q};
		gr_we    = 1'b0;
		gr_waddr = {si_q, sj_q};
		gr_wdata = '0;
		unique case (state_q)
			ST_INIT: begin
				gr_we = 1'b1;
			end
			ST_C_RD: begin
				gr_raddr = {crow_q[k_q], ccol_q[k_q]};
			end
			ST_C_WR: begin
				gr_we    = 1'b1;
				gr_waddr = {crow_q[k_q], ccol_q[k_q]};
				gr_wdata = k_q[1] ? gr_rdata - VW'(1) : gr_rdata + VW'(1);
			end
			ST_SCAN, ST_SCAN_END: begin
				gr_we    = valid_s1;
				gr_waddr = {i_s1, j_s1};
			end
			default: begin
			end
		endcase
	end

	// control, counters and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			width_q  <= SIDEW'(SIDE_RST);
			height_q <= SIDEW'(SIDE_RST);
			count_q  <= '0;
			p_q      <= '0;
			si_q     <= '0;
			sj_q     <= '0;
			k_q      <= '0;
			valid_s1 <= 1'b0;
			done     <= 1'b0;
			radius_q <= '0;
			best_q   <= '0;
			bx_q     <= '0;
			by_q     <= '0;
			rowacc_q <= '0;
			i_s1     <= '0;
			j_s1     <= '0;
			cok_q    <= '0;
			result   <= '0;
		end else begin
			// strobe the result and the scan stage from the current state
			done     <= (state_q == ST_DONE);
			valid_s1 <= (state_q == ST_SCAN);

			// configuration writes
			if (cfg_we) begin
				if (cfg_idx == REG_CITY_WIDTH) begin
					width_q <= sat_data;
				end else begin
					height_q <= sat_data;
				end
			end

			// hold scan pipeline results
			if (valid_s1) begin
				rowacc_q <= rs;
				if (qual && win) begin
					best_q <= val;
					bx_q   <= CW'(x_s);
					by_q   <= CW'(y_s);
				end
			end

			unique case (state_q)
				ST_INIT: begin
					if (sj_q == CW'(GRID_SIDE - 1)) begin
						sj_q <= '0;
						if (si_q == CW'(GRID_SIDE - 1)) begin
							si_q    <= '0;
							state_q <= ST_IDLE;
						end else begin
							si_q <= si_q + CW'(1);
						end
					end else begin
						sj_q <= sj_q + CW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (item.action)
							ACT_CLEAR: count_q <= '0;
							ACT_ADD: begin
								if (pt_we) begin
									count_q <= count_q + PCW'(1);
								end
							end
							ACT_QUERY: begin
								radius_q <= item.radius;
								best_q   <= '0;
								bx_q     <= CW'(1);
								by_q     <= CW'(1);
								p_q      <= '0;
								si_q     <= '0;
								sj_q     <= '0;
								state_q  <= (count_q == '0) ? ST_SCAN : ST_PT_RD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PT_RD: begin
					state_q <= ST_PT_LAT;
				end
				ST_PT_LAT: begin
					for (int c = 0; c < 4; c++) begin
						crow_q[c] <= (cr[c] < 0) ? '0 : CW'(cr[c]);
						ccol_q[c] <= (cc[c] < 0) ? '0 : CW'(cc[c]);
						cok_q[c]  <= (cr[c] < g_s) && (cc[c] < g_s);
					end
					k_q     <= '0;
					state_q <= ST_C_RD;
				end
				ST_C_RD: begin
					if (cok_q[k_q]) begin
						state_q <= ST_C_WR;
					end else if (k_q != 2'd3) begin
						k_q <= k_q + 2'd1;
					end else if (p_q + PCW'(1) == count_q) begin
						state_q <= ST_SCAN;
					end else begin
						p_q     <= p_q + PCW'(1);
						state_q <= ST_PT_RD;
					end
				end
				ST_C_WR: begin
					if (k_q != 2'd3) begin
						k_q     <= k_q + 2'd1;
						state_q <= ST_C_RD;
					end else if (p_q + PCW'(1) == count_q) begin
						state_q <= ST_SCAN;
					end else begin
						p_q     <= p_q + PCW'(1);
						state_q <= ST_PT_RD;
					end
				end
				ST_SCAN: begin
					i_s1     <= si_q;
					j_s1     <= sj_q;
					if (sj_q == g - CW'(1)) begin
						sj_q <= '0;
						if (si_q == g - CW'(1)) begin
							si_q    <= '0;
							state_q <= ST_SCAN_END;
						end else begin
							si_q <= si_q + CW'(1);
						end
					end else begin
						sj_q <= sj_q + CW'(1);
					end
				end
				ST_SCAN_END: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					result.best_count <= 15'(best_q);
					result.best_x     <= 9'(bx_q);
					result.best_y     <= 9'(by_q);
					state_q           <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mrbl_ram.sv -----
`default_nettype none
module mrbl_ram #(
	parameter int W     = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
